FILE: hw/rtl/lpt_pkg.sv
// Shared constants, types and index tables for the two-view triangulation pipeline.
// Nothing to import; every other file of the block takes this package in.
package lpt_pkg;

    localparam int COEF_BITS   = 16;
    localparam int COORD_BITS  = 16;
    localparam int RESULT_BITS = 32;
    localparam int COORD_FRAC  = COORD_BITS - 4;
    localparam int RESULT_FRAC = RESULT_BITS / 2;

    localparam int CFG_W     = 4 * COEF_BITS;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    localparam logic [CFG_IDX_W-1:0] REG_CAM1_ROW0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAM1_ROW1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CAM1_ROW2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CAM2_ROW0 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CAM2_ROW1 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CAM2_ROW2 = CFG_IDX_W'(5);

    localparam logic [CFG_W-1:0] ROW0_RESET = CFG_W'(8192);
    localparam logic [CFG_W-1:0] ROW1_RESET = CFG_W'(8192) << COEF_BITS;
    localparam logic [CFG_W-1:0] ROW2_RESET = CFG_W'(8192) << (2 * COEF_BITS);

    // linear system and normal-equation widths
    localparam int SYS_ROWS = 4;
    localparam int SYS_COLS = 3;
    localparam int SYS_W    = COORD_BITS + COEF_BITS;
    localparam int GRAM_W   = 2 * SYS_W;
    localparam int GRAM_N   = 6;
    localparam int COF_W    = 2 * GRAM_W - 1;

    // wide multiplier: magnitudes split into limbs
    localparam int LIMB_W      = 32;
    localparam int MUL_A_W     = COF_W;
    localparam int MUL_B_W     = GRAM_W;
    localparam int MUL_A_LIMBS = (MUL_A_W + LIMB_W - 1) / LIMB_W;
    localparam int MUL_B_LIMBS = (MUL_B_W + LIMB_W - 1) / LIMB_W;
    localparam int MA_W        = MUL_A_LIMBS * LIMB_W;
    localparam int MB_W        = MUL_B_LIMBS * LIMB_W;
    localparam int MUL_ROW_W   = MA_W + LIMB_W;
    localparam int MUL_P_W     = MA_W + MB_W;
    localparam int MUL_LAT     = 5;
    localparam int DET_W       = MUL_P_W;

    // divider
    localparam int QUO_W   = RESULT_BITS + 1;
    localparam int REM_W   = DET_W + QUO_W + 1;
    localparam int OVR_SH  = QUO_W - RESULT_FRAC - 1;
    localparam int DIV_LAT = QUO_W + 3;

    localparam int PIPE_DEPTH = 4 + 2 * MUL_LAT + 2 + DIV_LAT + 1;

    // unique entries of the symmetric normal matrix
    localparam int G00 = 0;
    localparam int G01 = 1;
    localparam int G02 = 2;
    localparam int G11 = 3;
    localparam int G12 = 4;
    localparam int G22 = 5;

    localparam int GRAM_ROW [GRAM_N] = '{0, 0, 0, 1, 1, 2};
    localparam int GRAM_COL [GRAM_N] = '{0, 1, 2, 1, 2, 2};

    // adjugate entry = m[p0]*m[p1] - m[n0]*m[n1], same order as the gram entries
    localparam int COF_POS [GRAM_N][2] = '{'{G11, G22}, '{G02, G12}, '{G01, G12},
                                           '{G00, G22}, '{G01, G02}, '{G00, G11}};
    localparam int COF_NEG [GRAM_N][2] = '{'{G12, G12}, '{G01, G22}, '{G02, G11},
                                           '{G02, G02}, '{G00, G12}, '{G01, G01}};

    // adjugate row k, column i
    localparam int ADJ_SEL [SYS_COLS][SYS_COLS] = '{'{G00, G01, G02},
                                                   '{G01, G11, G12},
                                                   '{G02, G12, G22}};

    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic signed [RESULT_BITS-1:0] t_result;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SINGULAR = 2'd1,
        STATUS_SAT      = 2'd2
    } t_status;

endpackage

FILE: hw/rtl/lpt_pair_if.sv
// Input channel: one matched point pair per word, valid/ready handshake.
// Depends on lpt_pkg for the coordinate type.
interface lpt_pair_if;
    import lpt_pkg::*;

    logic   valid;
    logic   ready;
    t_coord first_u;
    t_coord first_v;
    t_coord second_u;
    t_coord second_v;

    modport source (output valid, output first_u, output first_v,
                    output second_u, output second_v, input ready);
    modport sink   (input valid, input first_u, input first_v,
                    input second_u, input second_v, output ready);
endinterface

FILE: hw/rtl/lpt_point_if.sv
// Output channel: one reconstructed point and its status per word.
// Depends on lpt_pkg for the result and status types.
interface lpt_point_if;
    import lpt_pkg::*;

    logic    valid;
    logic    ready;
    t_result point_x;
    t_result point_y;
    t_result point_z;
    t_status solve_status;

    modport source (output valid, output point_x, output point_y,
                    output point_z, output solve_status, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input point_z, input solve_status, output ready);
endinterface

FILE: hw/rtl/lpt_wmul.sv
// Pipelined signed wide multiplier built from 32x32 limb products.
// Five register stages; depends on lpt_pkg for widths.
module lpt_wmul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [lpt_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [lpt_pkg::MUL_B_W-1:0] i_b,
    output logic signed [lpt_pkg::MUL_P_W-1:0] o_p
);
    import lpt_pkg::*;

    logic signed [MA_W-1:0]      a_ext;
    logic signed [MB_W-1:0]      b_ext;
    logic [MA_W-1:0]             r_ma;
    logic [MB_W-1:0]             r_mb;
    logic [2*LIMB_W-1:0]         r_pp [MUL_A_LIMBS][MUL_B_LIMBS];
    logic [MUL_ROW_W-1:0]        n_row [MUL_B_LIMBS];
    logic [MUL_ROW_W-1:0]        r_row [MUL_B_LIMBS];
    logic [MUL_P_W-1:0]          n_mag;
    logic [MUL_P_W-1:0]          r_mag;
    logic                        r_neg [MUL_LAT-1];

    assign a_ext = MA_W'(i_a);
    assign b_ext = MB_W'(i_b);

    always_comb begin
        for (int j = 0; j < MUL_B_LIMBS; j++) begin
            n_row[j] = '0;
            for (int i = 0; i < MUL_A_LIMBS; i++) begin
                n_row[j] = n_row[j] + (MUL_ROW_W'(r_pp[i][j]) << (i * LIMB_W));
            end
        end
    end

    always_comb begin
        n_mag = '0;
        for (int j = 0; j < MUL_B_LIMBS; j++) begin
            n_mag = n_mag + (MUL_P_W'(r_row[j]) << (j * LIMB_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // take magnitudes, keep the product sign aside
            r_ma     <= a_ext[MA_W-1] ? -a_ext : a_ext;
            r_mb     <= b_ext[MB_W-1] ? -b_ext : b_ext;
            r_neg[0] <= i_a[MUL_A_W-1] ^ i_b[MUL_B_W-1];
            for (int i = 0; i < MUL_A_LIMBS; i++) begin
                for (int j = 0; j < MUL_B_LIMBS; j++) begin
                    r_pp[i][j] <= r_ma[i*LIMB_W +: LIMB_W] * r_mb[j*LIMB_W +: LIMB_W];
                end
            end
            for (int s = 1; s < MUL_LAT - 1; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            r_row <= n_row;
            r_mag <= n_mag;
            o_p   <= r_neg[MUL_LAT-2] ? -r_mag : r_mag;
        end
    end

endmodule

FILE: hw/rtl/lpt_divider.sv
// Pipelined restoring divider: rounds num/den to Q16.16 and saturates.
// One quotient bit per stage; depends on lpt_pkg for widths.
module lpt_divider (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [lpt_pkg::DET_W-1:0] i_num,
    input  logic signed [lpt_pkg::DET_W-1:0] i_den,
    output lpt_pkg::t_result                 o_coord,
    output logic                             o_sat
);
    import lpt_pkg::*;

    logic [DET_W-1:0] r_nmag;
    logic [DET_W-1:0] r_dmag;
    logic             r_neg0;
    logic [REM_W-1:0] r_rem  [QUO_W+1];
    logic [QUO_W-1:0] r_q    [QUO_W+1];
    logic [DET_W-1:0] r_d    [QUO_W];
    logic             r_neg  [QUO_W+1];
    logic             r_over [QUO_W+1];

    logic [QUO_W:0]   q_inc;
    logic [QUO_W-1:0] mag;
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag_sat;
    logic             sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmag    <= i_num[DET_W-1] ? -i_num : i_num;
            r_dmag    <= i_den[DET_W-1] ? -i_den : i_den;
            r_neg0    <= i_num[DET_W-1] ^ i_den[DET_W-1];
            // quotient would not fit the kept bits: flag it now
            r_over[0] <= REM_W'(r_nmag) >= (REM_W'(r_dmag) << OVR_SH);
            r_rem[0]  <= REM_W'(r_nmag) << (RESULT_FRAC + 1);
            r_q[0]    <= '0;
            r_d[0]    <= r_dmag;
            r_neg[0]  <= r_neg0;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic [REM_W-1:0] dsh;
        logic             ge;

        assign dsh = REM_W'(r_d[s]) << (QUO_W - 1 - s);
        assign ge  = r_rem[s] >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= ge ? r_rem[s] - dsh : r_rem[s];
                r_q[s+1]    <= {r_q[s][QUO_W-2:0], ge};
                r_neg[s+1]  <= r_neg[s];
                r_over[s+1] <= r_over[s];
            end
        end

        if (s < QUO_W - 1) begin : g_dpass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[s+1] <= r_d[s];
                end
            end
        end
    end

    // round half away from zero on the magnitude, then clamp
    always_comb begin
        q_inc   = {1'b0, r_q[QUO_W]} + (QUO_W+1)'(1);
        mag     = q_inc[QUO_W:1];
        lim     = (QUO_W'(1) << (RESULT_BITS - 1)) - QUO_W'(!r_neg[QUO_W]);
        sat     = r_over[QUO_W] || (mag > lim);
        mag_sat = sat ? lim : mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_coord <= r_neg[QUO_W] ? -RESULT_BITS'(mag_sat) : RESULT_BITS'(mag_sat);
            o_sat   <= sat;
        end
    end

endmodule

FILE: hw/rtl/linear_point_triangulation_top.sv
// Two-view linear triangulation: point pair in, least-squares 3D point out.
// Uses lpt_pkg, lpt_pair_if, lpt_point_if, lpt_wmul and lpt_divider.
//
// Usage:
//   i_pair carries one matched pair (Q3.12) per word; o_point returns one
//   Q16.16 point and a status per word, in order. Six 64-bit camera rows
//   are written through i_cfg_we / i_cfg_idx / i_cfg_data while the block
//   is idle; an index of six or more is ignored.
// Pipeline and throughput:
//   53 register stages. One word enters per cycle while o_point is not
//   stalled; most of the depth comes from the
//   two rounds of limb multipliers (5 stages each) and the divider, which
//   resolves one quotient bit per stage (33 stages plus 3).
// Reset:
//   Clears every valid bit and loads identity cameras [I | 0].
// Stall:
//   While o_point holds a word that is not taken, every stage holds and
//   i_pair.ready is low; nothing is dropped or repeated.
module linear_point_triangulation_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lpt_pkg::CFG_W-1:0]       i_cfg_data,
    lpt_pair_if.sink                        i_pair,
    lpt_point_if.source                     o_point
);
    import lpt_pkg::*;

    logic                     adv;
    logic [PIPE_DEPTH-1:0]    r_vld;
    logic [CFG_W-1:0]         r_cam [NUM_REGS];

    t_coord                   r_pt [SYS_ROWS];
    logic signed [SYS_W-1:0]  n_a  [SYS_ROWS][SYS_COLS];
    logic signed [SYS_W-1:0]  n_b  [SYS_ROWS];
    logic signed [SYS_W-1:0]  r_a  [SYS_ROWS][SYS_COLS];
    logic signed [SYS_W-1:0]  r_b  [SYS_ROWS];
    logic signed [GRAM_W-1:0] r_pm [GRAM_N][SYS_ROWS];
    logic signed [GRAM_W-1:0] r_pc [SYS_COLS][SYS_ROWS];
    logic signed [GRAM_W-1:0] r_m  [GRAM_N];
    logic signed [GRAM_W-1:0] r_c  [SYS_COLS];
    logic signed [GRAM_W-1:0] r_dm [MUL_LAT+1][SYS_COLS];
    logic signed [GRAM_W-1:0] r_dc [MUL_LAT+1][SYS_COLS];

    logic signed [MUL_P_W-1:0] p_pos [GRAM_N];
    logic signed [MUL_P_W-1:0] p_neg [GRAM_N];
    logic signed [COF_W-1:0]   r_cof [GRAM_N];
    logic signed [MUL_P_W-1:0] p_d   [SYS_COLS+1][SYS_COLS];
    logic signed [DET_W-1:0]   r_den;
    logic signed [DET_W-1:0]   r_num [SYS_COLS];
    logic                      r_zero [DIV_LAT];

    t_result                  dq    [SYS_COLS];
    logic                     dsat  [SYS_COLS];
    t_result                  r_res [SYS_COLS];
    t_status                  r_status;

    function automatic t_coef coef_of(input logic [CFG_W-1:0] row, input int col);
        return row[col*COEF_BITS +: COEF_BITS];
    endfunction

    // the whole pipe moves unless the output word is held
    assign adv          = !r_vld[PIPE_DEPTH-1] || o_point.ready;
    assign i_pair.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[REG_CAM1_ROW0] <= ROW0_RESET;
            r_cam[REG_CAM1_ROW1] <= ROW1_RESET;
            r_cam[REG_CAM1_ROW2] <= ROW2_RESET;
            r_cam[REG_CAM2_ROW0] <= ROW0_RESET;
            r_cam[REG_CAM2_ROW1] <= ROW1_RESET;
            r_cam[REG_CAM2_ROW2] <= ROW2_RESET;
        end else if (i_cfg_we && (i_cfg_idx <= REG_CAM2_ROW2)) begin
            r_cam[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pair.valid};
        end
    end

    // rows u*P2 - P0 and v*P2 - P1 for each view, right side P0[3] - u*P2[3] and P1[3] - v*P2[3]
    always_comb begin
        logic signed [SYS_W:0] prod_w;
        logic signed [SYS_W:0] scl_w;
        for (int row = 0; row < SYS_ROWS; row++) begin
            for (int col = 0; col < SYS_COLS; col++) begin
                prod_w         = r_pt[row] * coef_of(r_cam[3*(row/2) + 2], col);
                scl_w          = coef_of(r_cam[3*(row/2) + (row%2)], col);
                scl_w          = scl_w <<< COORD_FRAC;
                n_a[row][col]  = SYS_W'(prod_w - scl_w);
            end
            prod_w   = r_pt[row] * coef_of(r_cam[3*(row/2) + 2], SYS_COLS);
            scl_w    = coef_of(r_cam[3*(row/2) + (row%2)], SYS_COLS);
            scl_w    = scl_w <<< COORD_FRAC;
            n_b[row] = SYS_W'(scl_w - prod_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pt[0] <= i_pair.first_u;
            r_pt[1] <= i_pair.first_v;
            r_pt[2] <= i_pair.second_u;
            r_pt[3] <= i_pair.second_v;
            r_a     <= n_a;
            r_b     <= n_b;
            for (int e = 0; e < GRAM_N; e++) begin
                for (int r = 0; r < SYS_ROWS; r++) begin
                    r_pm[e][r] <= r_a[r][GRAM_ROW[e]] * r_a[r][GRAM_COL[e]];
                end
                r_m[e] <= r_pm[e][0] + r_pm[e][1] + r_pm[e][2] + r_pm[e][3];
            end
            for (int i = 0; i < SYS_COLS; i++) begin
                for (int r = 0; r < SYS_ROWS; r++) begin
                    r_pc[i][r] <= r_a[r][i] * r_b[r];
                end
                r_c[i] <= r_pc[i][0] + r_pc[i][1] + r_pc[i][2] + r_pc[i][3];
            end
            // carry the first gram row and the right side past the cofactor round
            r_dm[0][0] <= r_m[G00];
            r_dm[0][1] <= r_m[G01];
            r_dm[0][2] <= r_m[G02];
            r_dc[0]    <= r_c;
            for (int s = 1; s <= MUL_LAT; s++) begin
                r_dm[s] <= r_dm[s-1];
                r_dc[s] <= r_dc[s-1];
            end
        end
    end

    // adjugate of the symmetric normal matrix
    for (genvar e = 0; e < GRAM_N; e++) begin : g_cof
        lpt_wmul u_mul_pos (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (MUL_A_W'(r_m[COF_POS[e][0]])),
            .i_b   (r_m[COF_POS[e][1]]),
            .o_p   (p_pos[e])
        );
        lpt_wmul u_mul_neg (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (MUL_A_W'(r_m[COF_NEG[e][0]])),
            .i_b   (r_m[COF_NEG[e][1]]),
            .o_p   (p_neg[e])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int e = 0; e < GRAM_N; e++) begin
                r_cof[e] <= COF_W'(p_pos[e] - p_neg[e]);
            end
        end
    end

    // q = 0: determinant along the first row; q = k+1: adjugate row k times rhs
    for (genvar q = 0; q <= SYS_COLS; q++) begin : g_det
        for (genvar i = 0; i < SYS_COLS; i++) begin : g_term
            lpt_wmul u_mul (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_a   (r_cof[ADJ_SEL[(q == 0) ? 0 : q-1][i]]),
                .i_b   ((q == 0) ? r_dm[MUL_LAT][i] : r_dc[MUL_LAT][i]),
                .o_p   (p_d[q][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den <= p_d[0][0] + p_d[0][1] + p_d[0][2];
            for (int k = 0; k < SYS_COLS; k++) begin
                r_num[k] <= p_d[k+1][0] + p_d[k+1][1] + p_d[k+1][2];
            end
            r_zero[0] <= (r_den == '0);
            for (int s = 1; s < DIV_LAT; s++) begin
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    for (genvar k = 0; k < SYS_COLS; k++) begin : g_div
        lpt_divider u_div (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_num   (r_num[k]),
            .i_den   (r_den),
            .o_coord (dq[k]),
            .o_sat   (dsat[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_zero[DIV_LAT-1]) begin
                r_res[0] <= '0;
                r_res[1] <= '0;
                r_res[2] <= '0;
                r_status <= STATUS_SINGULAR;
            end else begin
                r_res    <= dq;
                r_status <= (dsat[0] || dsat[1] || dsat[2]) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign o_point.valid        = r_vld[PIPE_DEPTH-1];
    assign o_point.point_x      = r_res[0];
    assign o_point.point_y      = r_res[1];
    assign o_point.point_z      = r_res[2];
    assign o_point.solve_status = r_status;

endmodule

FILE: hw/rtl/lpt_checker.sv
// Port-level checks for the triangulation block, bound to its top level.
// Depends on lpt_pkg for the status codes.
module lpt_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input lpt_pkg::t_result i_point_x,
    input lpt_pkg::t_result i_point_y,
    input lpt_pkg::t_result i_point_z,
    input lpt_pkg::t_status i_status
);
    import lpt_pkg::*;

    // a held output word must back-pressure the input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output word held");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_point_x) &&
            $stable(i_point_y) && $stable(i_point_z) && $stable(i_status)))
        else $error("held output word changed");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STATUS_SINGULAR)) |->
            ((i_point_x == '0) && (i_point_y == '0) && (i_point_z == '0)))
        else $error("singular system with nonzero point");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid straight after reset");

    // an empty output stage never holds back the input
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && i_in_valid) |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind linear_point_triangulation_top lpt_checker u_lpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_point.valid),
    .i_out_ready (o_point.ready),
    .i_point_x   (o_point.point_x),
    .i_point_y   (o_point.point_y),
    .i_point_z   (o_point.point_z),
    .i_status    (o_point.solve_status)
);
